/* sv/gbt_pkg.sv */
// ---------------------------------------------------------------------------
// gbt_pkg: shared types and constants for the graph breadth-first traversal
// Field widths, request and status codes, default table size.
// ---------------------------------------------------------------------------
package gbt_pkg;

   localparam int DEF_MAX_VERTICES = 64;

   localparam int TYPE_W   = 2;
   localparam int IDX_W    = 6;
   localparam int LABEL_W  = 8;
   localparam int STATUS_W = 2;

   typedef logic [TYPE_W-1:0]   req_kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam req_kind_type REQ_CLEAR      = 2'd0;
   localparam req_kind_type REQ_ADD_VERTEX = 2'd1;
   localparam req_kind_type REQ_ADD_EDGE   = 2'd2;
   localparam req_kind_type REQ_WALK       = 2'd3;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_TABLE_FULL = 2'd1;
   localparam status_type ST_BAD_INDEX  = 2'd2;
   localparam status_type ST_LIST_FULL  = 2'd3;

endpackage

/* sv/gbt_req_if.sv */
// ---------------------------------------------------------------------------
// gbt_req_if: request channel
// Valid/ready channel carrying one graph request per beat.
// ---------------------------------------------------------------------------
interface gbt_req_if;
   logic                        valid;
   logic                        ready;
   logic [gbt_pkg::TYPE_W-1:0]  req_type;
   logic [gbt_pkg::IDX_W-1:0]   vertex_a;
   logic [gbt_pkg::IDX_W-1:0]   vertex_b;
   logic [gbt_pkg::LABEL_W-1:0] vertex_label;

   modport source (output valid, req_type, vertex_a, vertex_b, vertex_label,
                   input ready);
   modport sink   (input valid, req_type, vertex_a, vertex_b, vertex_label,
                   output ready);
endinterface

/* sv/gbt_rsp_if.sv */
// ---------------------------------------------------------------------------
// gbt_rsp_if: response channel
// Valid/ready channel carrying one status or visit result per beat.
// ---------------------------------------------------------------------------
interface gbt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gbt_pkg::IDX_W-1:0]    visit_index;
   logic [gbt_pkg::LABEL_W-1:0]  visit_label;
   logic [gbt_pkg::STATUS_W-1:0] status;
   logic                         last;

   modport source (output valid, visit_index, visit_label, status, last,
                   input ready);
   modport sink   (input valid, visit_index, visit_label, status, last,
                   output ready);
endinterface

/* sv/gbt_ram.sv */
// ---------------------------------------------------------------------------
// gbt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ---------------------------------------------------------------------------
module gbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/graph_breadth_first_traversal.sv */
// ---------------------------------------------------------------------------
// graph_breadth_first_traversal: graph builder with breadth-first walk
// Holds vertex labels and per-vertex neighbor lists in RAM; a walk pops a
// RAM-based queue, reads each vertex's list newest first and emits visits.
// ---------------------------------------------------------------------------
// channel   bus       dir  fields
// request   req_bus   in   req_type, vertex_a, vertex_b, vertex_label
// response  rsp_bus   out  visit_index, visit_label, status, last
//
// Clear, add vertex and a bad index go straight to the response. Add edge:
// vertex RAM read, then read-modify-write of the neighbor count. Walk: per
// reached vertex a queue pop, queue RAM read and vertex RAM read, then one
// neighbor RAM read per stored edge; a bad start index also answers at once.
// One request at a time; the response register frees the core once loaded.
// Reset is synchronous; no RAM clearing pass. Response backpressure stalls
// the walk only where a visit beat must be loaded.
// ---------------------------------------------------------------------------
module graph_breadth_first_traversal #(
   parameter int MAX_VERTICES = gbt_pkg::DEF_MAX_VERTICES
) (
   input  logic      clock,
   input  logic      reset,
   gbt_req_if.sink   req_bus,
   gbt_rsp_if.source rsp_bus
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int NAW = $clog2(MAX_VERTICES * MAX_VERTICES);
   localparam int IW  = gbt_pkg::IDX_W;
   localparam int LW  = gbt_pkg::LABEL_W;
   localparam int XW  = (CW > IW) ? CW : IW;
   localparam int VRW = LW + CW;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EDGE_RD = 8'b0000_0010,
      S_EMIT    = 8'b0000_0100,
      S_W_POP   = 8'b0000_1000,
      S_W_QRD   = 8'b0001_0000,
      S_W_VRD   = 8'b0010_0000,
      S_W_NCHK  = 8'b0100_0000,
      S_W_FIN   = 8'b1000_0000
   } state_type;

   function automatic logic [NAW-1:0] nbr_addr(input logic [VW-1:0] v,
                                                input logic [CW-1:0] i);
      nbr_addr = NAW'(v) * NAW'(MAX_VERTICES) + NAW'(i);
   endfunction

   state_type            state_ff, state_in;
   logic [CW-1:0]        vc_ff, vc_in;
   logic [VW-1:0]        op_a_ff, op_a_in;
   logic [VW-1:0]        op_b_ff, op_b_in;
   gbt_pkg::status_type  stat_ff, stat_in;
   logic [CW-1:0]        head_ff, head_in;
   logic [CW-1:0]        tail_ff, tail_in;
   logic [VW-1:0]        cur_v_ff, cur_v_in;
   logic [CW-1:0]        nidx_ff, nidx_in;
   logic                 first_ff, first_in;
   logic [VW-1:0]        pend_idx_ff, pend_idx_in;
   logic [LW-1:0]        pend_lab_ff, pend_lab_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        rsp_idx_ff;
   logic [LW-1:0]        rsp_lab_ff;
   gbt_pkg::status_type  rsp_stat_ff;
   logic                 rsp_last_ff;

   logic                 out_load;
   logic [IW-1:0]        out_idx;
   logic [LW-1:0]        out_lab;
   gbt_pkg::status_type  out_stat;
   logic                 out_last;

   logic                 vram_we, vram_re;
   logic [VW-1:0]        vram_waddr, vram_raddr;
   logic [VRW-1:0]       vram_wdata, vram_rdata;
   logic                 nram_we, nram_re;
   logic [NAW-1:0]       nram_waddr, nram_raddr;
   logic [VW-1:0]        nram_wdata, nram_rdata;
   logic                 qram_we, qram_re;
   logic [VW-1:0]        qram_waddr, qram_raddr;
   logic [VW-1:0]        qram_wdata, qram_rdata;

   logic                 accept;
   logic                 out_free;
   logic [VW-1:0]        req_a_idx, req_b_idx;
   logic                 a_bad, b_bad;
   logic [CW-1:0]        v_cnt;
   logic [LW-1:0]        v_lab;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_a_idx     = VW'(req_bus.vertex_a);
   assign req_b_idx     = VW'(req_bus.vertex_b);
   assign a_bad         = XW'(req_bus.vertex_a) >= XW'(vc_ff);
   assign b_bad         = XW'(req_bus.vertex_b) >= XW'(vc_ff);
   assign v_cnt         = vram_rdata[CW-1:0];
   assign v_lab         = vram_rdata[VRW-1:CW];

   gbt_ram #(.WIDTH(VRW), .DEPTH(MAX_VERTICES)) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (vram_waddr),
      .wr_data (vram_wdata),
      .rd_en   (vram_re),
      .rd_addr (vram_raddr),
      .rd_data (vram_rdata)
   );

   gbt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_nbr_ram (
      .clock   (clock),
      .wr_en   (nram_we),
      .wr_addr (nram_waddr),
      .wr_data (nram_wdata),
      .rd_en   (nram_re),
      .rd_addr (nram_raddr),
      .rd_data (nram_rdata)
   );

   gbt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (qram_we),
      .wr_addr (qram_waddr),
      .wr_data (qram_wdata),
      .rd_en   (qram_re),
      .rd_addr (qram_raddr),
      .rd_data (qram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      vc_in       = vc_ff;
      op_a_in     = op_a_ff;
      op_b_in     = op_b_ff;
      stat_in     = stat_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_v_in    = cur_v_ff;
      nidx_in     = nidx_ff;
      first_in    = first_ff;
      pend_idx_in = pend_idx_ff;
      pend_lab_in = pend_lab_ff;
      visited_in  = visited_ff;

      out_load = 1'b0;
      out_idx  = '0;
      out_lab  = '0;
      out_stat = gbt_pkg::ST_OK;
      out_last = 1'b0;

      vram_we    = 1'b0;
      vram_waddr = '0;
      vram_wdata = '0;
      vram_re    = 1'b0;
      vram_raddr = '0;
      nram_we    = 1'b0;
      nram_waddr = '0;
      nram_wdata = '0;
      nram_re    = 1'b0;
      nram_raddr = '0;
      qram_we    = 1'b0;
      qram_waddr = '0;
      qram_wdata = '0;
      qram_re    = 1'b0;
      qram_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_a_in = req_a_idx;
               op_b_in = req_b_idx;
               unique case (req_bus.req_type)
                  gbt_pkg::REQ_CLEAR: begin
                     vc_in    = '0;
                     stat_in  = gbt_pkg::ST_OK;
                     state_in = S_EMIT;
                  end
                  gbt_pkg::REQ_ADD_VERTEX: begin
                     if (vc_ff == CW'(MAX_VERTICES)) begin
                        stat_in = gbt_pkg::ST_TABLE_FULL;
                     end else begin
                        vram_we    = 1'b1;
                        vram_waddr = vc_ff[VW-1:0];
                        vram_wdata = {req_bus.vertex_label, CW'(0)};
                        vc_in      = vc_ff + CW'(1);
                        stat_in    = gbt_pkg::ST_OK;
                     end
                     state_in = S_EMIT;
                  end
                  gbt_pkg::REQ_ADD_EDGE: begin
                     if (a_bad || b_bad) begin
                        stat_in  = gbt_pkg::ST_BAD_INDEX;
                        state_in = S_EMIT;
                     end else begin
                        vram_re    = 1'b1;
                        vram_raddr = req_a_idx;
                        state_in   = S_EDGE_RD;
                     end
                  end
                  gbt_pkg::REQ_WALK: begin
                     if (b_bad) begin
                        stat_in  = gbt_pkg::ST_BAD_INDEX;
                        state_in = S_EMIT;
                     end else begin
                        visited_in            = '0;
                        visited_in[req_b_idx] = 1'b1;
                        qram_we    = 1'b1;
                        qram_waddr = '0;
                        qram_wdata = req_b_idx;
                        head_in    = '0;
                        tail_in    = CW'(1);
                        first_in   = 1'b1;
                        state_in   = S_W_POP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_EDGE_RD: begin
            if (v_cnt == CW'(MAX_VERTICES)) begin
               stat_in = gbt_pkg::ST_LIST_FULL;
            end else begin
               nram_we    = 1'b1;
               nram_waddr = nbr_addr(op_a_ff, v_cnt);
               nram_wdata = op_b_ff;
               vram_we    = 1'b1;
               vram_waddr = op_a_ff;
               vram_wdata = {v_lab, v_cnt + CW'(1)};
               stat_in    = gbt_pkg::ST_OK;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_stat = stat_ff;
               out_last = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_W_POP: begin
            if (head_ff == tail_ff) begin
               state_in = S_W_FIN;
            end else begin
               qram_re    = 1'b1;
               qram_raddr = head_ff[VW-1:0];
               head_in    = head_ff + CW'(1);
               state_in   = S_W_QRD;
            end
         end

         S_W_QRD: begin
            vram_re    = 1'b1;
            vram_raddr = qram_rdata;
            cur_v_in   = qram_rdata;
            state_in   = S_W_VRD;
         end

         // previous visit goes out once the next one is known
         S_W_VRD: begin
            if (first_ff || out_free) begin
               if (!first_ff) begin
                  out_load = 1'b1;
                  out_idx  = IW'(pend_idx_ff);
                  out_lab  = pend_lab_ff;
               end
               pend_idx_in = cur_v_ff;
               pend_lab_in = v_lab;
               first_in    = 1'b0;
               if (v_cnt == '0) begin
                  state_in = S_W_POP;
               end else begin
                  nram_re    = 1'b1;
                  nram_raddr = nbr_addr(cur_v_ff, v_cnt - CW'(1));
                  nidx_in    = v_cnt - CW'(1);
                  state_in   = S_W_NCHK;
               end
            end
         end

         S_W_NCHK: begin
            if (!visited_ff[nram_rdata]) begin
               visited_in[nram_rdata] = 1'b1;
               qram_we    = 1'b1;
               qram_waddr = tail_ff[VW-1:0];
               qram_wdata = nram_rdata;
               tail_in    = tail_ff + CW'(1);
            end
            if (nidx_ff != '0) begin
               nram_re    = 1'b1;
               nram_raddr = nbr_addr(cur_v_ff, nidx_ff - CW'(1));
               nidx_in    = nidx_ff - CW'(1);
            end else begin
               state_in = S_W_POP;
            end
         end

         S_W_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               out_idx  = IW'(pend_idx_ff);
               out_lab  = pend_lab_ff;
               out_last = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vc_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         first_ff     <= 1'b1;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vc_ff        <= vc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         first_ff     <= first_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      stat_ff     <= stat_in;
      cur_v_ff    <= cur_v_in;
      nidx_ff     <= nidx_in;
      pend_idx_ff <= pend_idx_in;
      pend_lab_ff <= pend_lab_in;
      if (out_load) begin
         rsp_idx_ff  <= out_idx;
         rsp_lab_ff  <= out_lab;
         rsp_stat_ff <= out_stat;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.visit_index = rsp_idx_ff;
   assign rsp_bus.visit_label = rsp_lab_ff;
   assign rsp_bus.status      = rsp_stat_ff;
   assign rsp_bus.last        = rsp_last_ff;

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("walk queue head passed tail");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= CW'(MAX_VERTICES))
      else $error("walk queue overflow");

   a_vc_bound: assert property (@(posedge clock) disable iff (reset)
      vc_ff <= CW'(MAX_VERTICES))
      else $error("vertex count above table size");

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status != gbt_pkg::ST_OK) |-> rsp_bus.last)
      else $error("error status beat without last");

endmodule
